// File: hdl/dcwq_pkg.sv
// Shared types and constants for the deduplicating coordinate work queue.
package dcwq_pkg;

	// Queue geometry.
	localparam int QUEUE_DEPTH = 1024;
	localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// Field widths.
	localparam int COORD_W = 32;
	localparam int ENTRY_W = 3 * COORD_W;
	localparam int OCC_W   = 11;
	localparam int STAT_W  = 3;

	// Stream data widths, padded to whole bytes.
	localparam int S_TDATA_W = ((ENTRY_W + 7) / 8) * 8;
	localparam int M_DATA_W  = ENTRY_W + OCC_W;
	localparam int M_TDATA_W = ((M_DATA_W + 7) / 8) * 8;

	// Request kinds carried on the slave-side tuser.
	typedef enum logic [0:0] {
		CMD_ENQUEUE = 1'b0,
		CMD_DEQUEUE = 1'b1
	} cmd_t;

	// Result status carried on the master-side tuser.
	typedef enum logic [STAT_W-1:0] {
		ST_ENQUEUED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL      = 3'd2,
		ST_DEQUEUED  = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RESULT
	} state_t;

	// One stored coordinate triple, x in the lowest bits.
	typedef struct packed {
		logic signed [COORD_W-1:0] z;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} entry_t;

	// Memory port requests from the sequencer.
	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		entry_t            wr_data;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} mem_req_t;

	// One result transaction.
	typedef struct packed {
		logic [OCC_W-1:0] occupancy;
		entry_t           coord;
		status_t          status;
	} result_t;

endpackage

// File: hdl/dcwq_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module dcwq_ram #(
	parameter int DATA_W = 96,
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: hdl/dcwq_ctrl.sv
// Sequencer: ring pointers, duplicate scan with one shared comparator, result decision.
module dcwq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dcwq_pkg::cmd_t    in_cmd,
	input  dcwq_pkg::entry_t  in_coord,
	output dcwq_pkg::mem_req_t mem_req,
	input  dcwq_pkg::entry_t  rd_data,
	input  logic              out_free,
	output logic              res_valid,
	output dcwq_pkg::result_t res
);

	import dcwq_pkg::*;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(QUEUE_DEPTH);

	state_t            state_q, state_d;
	logic [ADDR_W-1:0] head_q, tail_q, scan_ptr_q;
	logic [CNT_W-1:0]  count_q, iss_q;
	logic              cmp_v_s1;
	entry_t            coord_q;
	status_t           status_q;

	logic accept, deq_rd, scan_rd, hit, scan_done, do_write;

	// Wrap a ring index.
	function automatic logic [ADDR_W-1:0] advance(input logic [ADDR_W-1:0] idx);
		advance = (idx == LAST_ADDR) ? '0 : idx + 1'b1;
	endfunction

	// Shared comparator and scan progress.
	assign accept    = in_valid && in_ready;
	assign hit       = cmp_v_s1 && (rd_data == coord_q);
	assign scan_done = (iss_q == count_q) && !cmp_v_s1;
	assign deq_rd    = accept && (in_cmd == CMD_DEQUEUE) && (count_q != '0);
	assign scan_rd   = (state_q == S_SCAN) && (iss_q != count_q) && !hit;
	assign do_write  = (state_q == S_SCAN) && scan_done && !hit && (count_q != FULL_CNT);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (in_cmd == CMD_DEQUEUE) ? S_RESULT : S_SCAN;
				end
			end
			S_SCAN: begin
				if (hit || scan_done) begin
					state_d = S_RESULT;
				end
			end
			S_RESULT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Output logic.
	always_comb begin
		in_ready         = (state_q == S_IDLE);
		res_valid        = (state_q == S_RESULT);
		mem_req.wr_en    = do_write;
		mem_req.wr_addr  = tail_q;
		mem_req.wr_data  = coord_q;
		mem_req.rd_en    = deq_rd || scan_rd;
		mem_req.rd_addr  = deq_rd ? head_q : scan_ptr_q;
		res.status       = status_q;
		res.occupancy    = OCC_W'(count_q);
		res.coord        = (status_q == ST_DEQUEUED) ? rd_data : '0;
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Ring pointers, count and scan bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			scan_ptr_q <= '0;
			iss_q      <= '0;
			cmp_v_s1   <= 1'b0;
			status_q   <= ST_ENQUEUED;
		end else begin
			cmp_v_s1 <= scan_rd;
			if (accept) begin
				scan_ptr_q <= head_q;
				iss_q      <= '0;
				if (in_cmd == CMD_DEQUEUE) begin
					if (count_q == '0) begin
						status_q <= ST_EMPTY;
					end else begin
						status_q <= ST_DEQUEUED;
						head_q   <= advance(head_q);
						count_q  <= count_q - 1'b1;
					end
				end
			end
			if (scan_rd) begin
				scan_ptr_q <= advance(scan_ptr_q);
				iss_q      <= iss_q + 1'b1;
			end
			if (state_q == S_SCAN) begin
				if (hit) begin
					status_q <= ST_DUPLICATE;
				end else if (scan_done) begin
					if (count_q == FULL_CNT) begin
						status_q <= ST_FULL;
					end else begin
						status_q <= ST_ENQUEUED;
						tail_q   <= advance(tail_q);
						count_q  <= count_q + 1'b1;
					end
				end
			end
		end
	end

	// Request coordinates held for the scan and the tail write.
	always_ff @(posedge clk) begin
		if (accept) begin
			coord_q <= in_coord;
		end
	end

endmodule

// File: hdl/dedup_coordinate_work_queue.sv
// Top level of the deduplicating coordinate work queue with stream ports.
//
//  Channel  | Direction | tdata (low bit up)                         | tuser
//  s_axis   | in        | coord_x, coord_y, coord_z                  | cmd
//  m_axis   | out       | out_x, out_y, out_z, occupancy, zero pad   | status
//
// A dequeue goes from acceptance straight to the result state; an enqueue
// into an empty queue passes through the scan state without a read. An
// enqueue scans the pending entries one per cycle through the single memory
// read port and comparator, and a duplicate ends the scan early.
// The block takes one request at a time.
// Reset clears pointers and count; the entry memory is not cleared.
// A stalled result sits in the output register; a new request is accepted
// meanwhile, and its result waits until the register drains.
module dedup_coordinate_work_queue (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [dcwq_pkg::S_TDATA_W-1:0] s_axis_tdata,  // coord_x, coord_y, coord_z
	input  logic                           s_axis_tuser,  // cmd
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [dcwq_pkg::M_TDATA_W-1:0] m_axis_tdata,  // out_x, out_y, out_z, occupancy
	output logic [dcwq_pkg::STAT_W-1:0]    m_axis_tuser   // status
);

	import dcwq_pkg::*;

	mem_req_t mem_req;
	entry_t   rd_data;
	entry_t   in_coord;
	cmd_t     in_cmd;
	result_t  res, out_q;
	logic     res_valid, out_valid_q, out_free;

	// Unpack the request transaction.
	assign in_coord = entry_t'(s_axis_tdata[ENTRY_W-1:0]);
	assign in_cmd   = cmd_t'(s_axis_tuser);

	dcwq_ram #(
		.DATA_W (ENTRY_W),
		.DEPTH  (QUEUE_DEPTH),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem_req.wr_en),
		.wr_addr (mem_req.wr_addr),
		.wr_data (mem_req.wr_data),
		.rd_en   (mem_req.rd_en),
		.rd_addr (mem_req.rd_addr),
		.rd_data (rd_data)
	);

	dcwq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (in_cmd),
		.in_coord  (in_coord),
		.mem_req   (mem_req),
		.rd_data   (rd_data),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output register decouples the result from the sequencer.
	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			out_q <= res;
		end
	end

	// Pack the result transaction.
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tdata  = {{(M_TDATA_W - M_DATA_W){1'b0}}, out_q.occupancy, out_q.coord};

endmodule
